@@ rtl/core/psrd_pkg.sv @@
// psrd_pkg: shared types and constants for the peak step-rate detector
// no dependencies; used by psrd_div and peak_step_rate_detector
package psrd_pkg;

  // step rate result width and the Q8 rate numerator (1000 ms * 256)
  localparam int unsigned RATE_W = 18;
  localparam logic [RATE_W-1:0] RATE_NUM = 18'd256000;
  localparam logic [RATE_W-1:0] RATE_MAX = 18'h3FFFF;

  // peak threshold register, Q8.8 m/s^2, reset is 10.3 truncated
  localparam int unsigned THRESH_W = 16;
  localparam logic signed [THRESH_W-1:0] THRESH_RESET = 16'sd2636;

  // divider iteration counter, counts 0..RATE_W
  localparam int unsigned DIV_CNT_W = $clog2(RATE_W + 1);

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/peak_step_rate_detector.sv @@
// peak_step_rate_detector: three-point peak detector with threshold and step-rate output
// depends on psrd_pkg and psrd_div
//
// Takes timestamped acceleration samples (ms, signed Q8.8) one transaction at a time and
// holds a three-sample window. Each sample after the second judges the middle one and
// emits its time and value, a peak flag on out_tuser and, for a peak, the step rate
// 256000 / (ms since previous peak) in Q8 Hz, saturated to all ones on a zero gap.
// The first sample, or any sample with in_tuser set, restarts the window and seeds the
// last peak time; it and the second sample give no result. The input is taken only when
// the sequencer is idle: a sample that gives no result only passes S_EVAL, one that gives a
// result without a divide passes S_EVAL and S_OUT, and a peak whose rate goes through
// the shared restoring divider (18 quotient bits, one per cycle) passes S_EVAL, S_DIV and
// S_OUT; S_OUT holds until the output register is free, and the next sample can be accepted
// once the sequencer is back in S_IDLE. A finished result waits in the output register
// and blocks only the following result, not the following transaction. The threshold
// register may be written at any time the block is idle; cfg_ready is always high.
module peak_step_rate_detector #(
  parameter int unsigned TIME_WIDTH   = 48,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  // input samples
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // [TIME_WIDTH-1:0] sample_time, then sample_value, zero padded to bytes
  input  logic [((TIME_WIDTH+SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  // [0] start_req
  input  logic                       in_tuser,
  // judged samples
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [TIME_WIDTH-1:0] out_time, then out_value, then step_rate, zero padded to bytes
  output logic [((TIME_WIDTH+SAMPLE_WIDTH+psrd_pkg::RATE_W+7)/8)*8-1:0] out_tdata,
  // [0] peak
  output logic                       out_tuser,
  // threshold register write
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [psrd_pkg::THRESH_W-1:0] cfg_data
);

  localparam int unsigned OUT_DW = ((TIME_WIDTH+SAMPLE_WIDTH+psrd_pkg::RATE_W+7)/8)*8;
  // compare width wide enough for both sample and threshold
  localparam int unsigned CMP_W  = (SAMPLE_WIDTH > psrd_pkg::THRESH_W) ?
                                   SAMPLE_WIDTH : psrd_pkg::THRESH_W;

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [1:0]                       fill_r, fill_nxt;
  logic signed [psrd_pkg::THRESH_W-1:0] thr_r, thr_nxt;

  // accepted sample
  logic [TIME_WIDTH-1:0]            new_time_r, new_time_nxt;
  logic signed [SAMPLE_WIDTH-1:0]   new_value_r, new_value_nxt;
  logic                             new_start_r, new_start_nxt;

  // window and last peak time
  logic signed [SAMPLE_WIDTH-1:0]   older_r, older_nxt;
  logic signed [SAMPLE_WIDTH-1:0]   middle_r, middle_nxt;
  logic [TIME_WIDTH-1:0]            mid_time_r, mid_time_nxt;
  logic [TIME_WIDTH-1:0]            last_peak_r, last_peak_nxt;

  // pending result
  logic [TIME_WIDTH-1:0]            res_time_r, res_time_nxt;
  logic signed [SAMPLE_WIDTH-1:0]   res_value_r, res_value_nxt;
  logic                             res_peak_r, res_peak_nxt;
  logic [psrd_pkg::RATE_W-1:0]      res_rate_r, res_rate_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic [TIME_WIDTH-1:0]            out_time_r, out_time_nxt;
  logic signed [SAMPLE_WIDTH-1:0]   out_value_r, out_value_nxt;
  logic                             out_peak_r, out_peak_nxt;
  logic [psrd_pkg::RATE_W-1:0]      out_rate_r, out_rate_nxt;

  // evaluation terms
  logic signed [CMP_W-1:0]          mid_ext, thr_ext;
  logic                             is_peak;
  logic [TIME_WIDTH-1:0]            gap;
  logic [63:0]                      gap_ext;
  logic                             gap_fits;

  // divider hookup
  logic                             div_start;
  logic [psrd_pkg::RATE_W-1:0]      div_quo;
  psrd_pkg::div_stat_t              div_stat;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign mid_ext  = CMP_W'(middle_r);
  assign thr_ext  = CMP_W'(thr_r);
  assign is_peak  = (middle_r > older_r) && (middle_r > new_value_r) && (mid_ext > thr_ext);
  // gap wraps modulo 2^TIME_WIDTH on decreasing timestamps
  assign gap      = mid_time_r - last_peak_r;
  assign gap_ext  = 64'(gap);
  // any gap at or above 2^RATE_W ms gives a zero quotient
  assign gap_fits = ((gap_ext >> psrd_pkg::RATE_W) == 64'd0);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    thr_nxt       = thr_r;
    new_time_nxt  = new_time_r;
    new_value_nxt = new_value_r;
    new_start_nxt = new_start_r;
    older_nxt     = older_r;
    middle_nxt    = middle_r;
    mid_time_nxt  = mid_time_r;
    last_peak_nxt = last_peak_r;
    res_time_nxt  = res_time_r;
    res_value_nxt = res_value_r;
    res_peak_nxt  = res_peak_r;
    res_rate_nxt  = res_rate_r;
    out_valid_nxt = out_valid_r;
    out_time_nxt  = out_time_r;
    out_value_nxt = out_value_r;
    out_peak_nxt  = out_peak_r;
    out_rate_nxt  = out_rate_r;
    div_start     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      thr_nxt = cfg_data;
    end

    // output register drains independently of the sequencer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          new_time_nxt  = in_tdata[TIME_WIDTH-1:0];
          new_value_nxt = in_tdata[TIME_WIDTH+SAMPLE_WIDTH-1:TIME_WIDTH];
          new_start_nxt = in_tuser;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (new_start_r || (fill_r == 2'd0)) begin
          // restart: sample seeds the window and the last peak time
          older_nxt     = '0;
          middle_nxt    = new_value_r;
          mid_time_nxt  = new_time_r;
          last_peak_nxt = new_time_r;
          fill_nxt      = 2'd1;
          state_nxt     = S_IDLE;
        end else if (fill_r == 2'd1) begin
          older_nxt    = middle_r;
          middle_nxt   = new_value_r;
          mid_time_nxt = new_time_r;
          fill_nxt     = 2'd2;
          state_nxt    = S_IDLE;
        end else begin
          res_time_nxt  = mid_time_r;
          res_value_nxt = middle_r;
          res_peak_nxt  = is_peak;
          res_rate_nxt  = '0;
          state_nxt     = S_OUT;
          if (is_peak) begin
            last_peak_nxt = mid_time_r;
            if (gap == '0) begin
              res_rate_nxt = psrd_pkg::RATE_MAX;
            end else if (gap_fits) begin
              div_start = 1'b1;
              state_nxt = S_DIV;
            end
          end
          older_nxt    = middle_r;
          middle_nxt   = new_value_r;
          mid_time_nxt = new_time_r;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_rate_nxt = div_quo;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        // load once the previous result has left
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_time_nxt  = res_time_r;
          out_value_nxt = res_value_r;
          out_peak_nxt  = res_peak_r;
          out_rate_nxt  = res_rate_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= 2'd0;
      thr_r       <= psrd_pkg::THRESH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      thr_r       <= thr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    new_time_r  <= new_time_nxt;
    new_value_r <= new_value_nxt;
    new_start_r <= new_start_nxt;
    older_r     <= older_nxt;
    middle_r    <= middle_nxt;
    mid_time_r  <= mid_time_nxt;
    last_peak_r <= last_peak_nxt;
    res_time_r  <= res_time_nxt;
    res_value_r <= res_value_nxt;
    res_peak_r  <= res_peak_nxt;
    res_rate_r  <= res_rate_nxt;
    out_time_r  <= out_time_nxt;
    out_value_r <= out_value_nxt;
    out_peak_r  <= out_peak_nxt;
    out_rate_r  <= out_rate_nxt;
  end

  // shared divider for the rate quotient
  psrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (gap_ext[psrd_pkg::RATE_W-1:0]),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_rate_r, out_value_r, out_time_r});
  assign out_tuser  = out_peak_r;

  // a non-peak result never carries a rate
  a_rate_zero_no_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_peak_r) |-> (out_rate_r == '0))
    else $error("nonzero step rate on a non-peak result");

  // while waiting on the divider it must be running or just finished
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("sequencer waits on an idle divider");

  // a new result only comes out of the output stage
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result raised outside the output stage");

  // window fill never exceeds two held samples
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("window fill count out of range");

endmodule

@@ rtl/core/psrd_div.sv @@
// psrd_div: restoring divider computing RATE_NUM / divisor, one quotient bit per cycle
// depends on psrd_pkg
module psrd_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [psrd_pkg::RATE_W-1:0]     divisor,
  output psrd_pkg::div_stat_t             stat,
  output logic [psrd_pkg::RATE_W-1:0]     quotient
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [psrd_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [psrd_pkg::RATE_W-1:0]       rem_r, rem_nxt;
  logic [psrd_pkg::RATE_W-1:0]       num_r, num_nxt;
  logic [psrd_pkg::RATE_W-1:0]       dvs_r, dvs_nxt;
  logic [psrd_pkg::RATE_W:0]         trial;
  logic                              take;

  // shift next numerator bit into the partial remainder and try to subtract
  assign trial = {rem_r, num_r[psrd_pkg::RATE_W-1]};
  assign take  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      num_nxt  = psrd_pkg::RATE_NUM;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // remainder stays below the numerator, so it fits in RATE_W bits
      rem_nxt = take ? psrd_pkg::RATE_W'(trial - {1'b0, dvs_r})
                     : psrd_pkg::RATE_W'(trial);
      num_nxt = {num_r[psrd_pkg::RATE_W-2:0], take};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == psrd_pkg::DIV_CNT_W'(psrd_pkg::RATE_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = num_r;

endmodule
